// ===== rtl/wfp_pkg.sv =====
// Shared types, constants and the fixed-point sine used by the FFT peak finder.
// Depends on nothing; every other file of the block but wfp_fifo refers to it by scoped names.
package wfp_pkg;

   // Fixed widths of the external fields and of the working store.
   localparam int SAMPLE_W   = 16;
   localparam int STORE_W    = 18;
   localparam int MAG_W      = 16;
   localparam int BIN_OUT_W  = 7;
   localparam int QBIN_W     = 8;
   localparam int ADDR_MAX_W = 12;
   localparam int SQRT_STEPS = 18;

   // Queue between the front and the back, and the result queue.
   localparam int MID_DEPTH = 4;
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
   localparam int OUT_DEPTH = 2;

   // Configuration registers.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_LOW  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_HIGH = 4'd1;
   localparam logic [6:0] AUTO_LOW_RESET  = 7'd5;
   localparam logic [7:0] AUTO_HIGH_RESET = 8'd51;

   // Item kinds and result sources.
   localparam logic KIND_QUERY   = 1'b1;
   localparam logic SRC_WINDOW   = 1'b0;
   localparam logic SRC_QUERY    = 1'b1;

   // Sine polynomial coefficients, phase in turns scaled by 2^32.
   localparam logic [63:0] QUARTER_TURN = 64'h0000_0000_4000_0000;
   localparam logic [63:0] SIN_C1 = 64'd1686629713;
   localparam logic [63:0] SIN_C3 = 64'd693598668;
   localparam logic [63:0] SIN_C5 = 64'd85569306;
   localparam logic [63:0] SIN_C7 = 64'd5026995;
   localparam logic [63:0] SIN_C9 = 64'd172272;

   typedef struct packed {
      logic                       kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic [QBIN_W-1:0]          query_low_bin;
      logic [QBIN_W-1:0]          query_high_bin;
   } req_type;

   typedef struct packed {
      logic                 source;
      logic [BIN_OUT_W-1:0] peak_bin;
      logic [MAG_W-1:0]     peak_magnitude;
   } rsp_type;

   typedef enum logic {
      JOB_SAMPLE = 1'b0,
      JOB_QUERY  = 1'b1
   } job_kind_type;

   // One classified job passed from the front to the back.
   typedef struct packed {
      job_kind_type              kind;
      logic                      last;
      logic [ADDR_MAX_W-1:0]     addr;
      logic signed [STORE_W-1:0] value;
      logic [QBIN_W-1:0]         qlo;
      logic [QBIN_W-1:0]         qhi;
   } job_type;

   // Q15 sine of a 32-bit phase; only evaluated when tables are built.
   function automatic logic signed [15:0] sin_q15(input logic [31:0] ph);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] q;
      z = {34'd0, ph[29:0]};
      if (ph[30]) begin
         z = QUARTER_TURN - z;
      end
      z2 = (z * z) >> 30;
      t  = SIN_C7 - ((z2 * SIN_C9) >> 30);
      t  = SIN_C5 - ((z2 * t) >> 30);
      t  = SIN_C3 - ((z2 * t) >> 30);
      t  = SIN_C1 - ((z2 * t) >> 30);
      s  = (z * t) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return ph[31] ? -$signed(q[15:0]) : $signed(q[15:0]);
   endfunction

endpackage

// ===== rtl/wfp_fifo.sv =====
// Small first-in first-out queue of register slots with an occupancy count.
// Depends on nothing; used for the job queue and the result queue.
module wfp_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               wdata,
   output logic                           full,
   input  logic                           pop,
   output logic [WIDTH-1:0]               rdata,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/wfp_front.sv =====
// Front end: accepts items, applies the Hann window and bit-reverses the address.
// Depends on wfp_pkg for the item types and the sine used to build the window table.
module wfp_front #(
   parameter int WINDOW_POINTS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  wfp_pkg::req_type               req_data,
   input  logic [wfp_pkg::MID_CNT_W-1:0]  mid_count,
   output logic                           mid_push,
   output wfp_pkg::job_type               mid_item
);

   localparam int LG      = $clog2(WINDOW_POINTS);
   localparam int WIN_DIV = WINDOW_POINTS - 1;
   localparam int SUM_W   = wfp_pkg::MID_CNT_W + 1;

   // Window coefficient (32768 - cos) / 2 for every sample position.
   function automatic logic [WINDOW_POINTS-1:0][15:0] build_window();
      logic [WINDOW_POINTS-1:0][15:0] tab;
      logic [31:0]                    ph;
      logic signed [15:0]             c;
      logic signed [17:0]             d;
      for (int i = 0; i < WINDOW_POINTS; i++) begin
         ph     = 32'((64'(i) << 32) / 64'(WIN_DIV));
         c      = wfp_pkg::sin_q15(ph + 32'(wfp_pkg::QUARTER_TURN));
         d      = 18'sd32768 - 18'(c);
         tab[i] = d[16:1];
      end
      return tab;
   endfunction

   localparam logic [WINDOW_POINTS-1:0][15:0] WIN = build_window();

   function automatic logic [LG-1:0] bit_rev(input logic [LG-1:0] v);
      logic [LG-1:0] r;
      for (int k = 0; k < LG; k++) begin
         r[k] = v[LG-1-k];
      end
      return r;
   endfunction

   logic                                     accept;
   logic [LG-1:0]                            count_ff, count_in;
   logic                                     s1_vld_ff;
   wfp_pkg::req_type                         s1_item_ff;
   logic [LG-1:0]                            s1_idx_ff;
   logic                                     s2_vld_ff;
   logic                                     s2_kind_ff;
   logic signed [wfp_pkg::SAMPLE_W-1:0]      s2_x_ff;
   logic [15:0]                              s2_w_ff;
   logic [LG-1:0]                            s2_addr_ff;
   logic                                     s2_last_ff;
   logic [wfp_pkg::QBIN_W-1:0]               s2_qlo_ff;
   logic [wfp_pkg::QBIN_W-1:0]               s2_qhi_ff;
   logic signed [32:0]                       prod;
   logic signed [33:0]                       rounded;

   // Room is reserved for every item already in the two stages.
   assign req_full = (SUM_W'(mid_count) + SUM_W'(s1_vld_ff) + SUM_W'(s2_vld_ff))
                     >= SUM_W'(wfp_pkg::MID_DEPTH);
   assign accept   = req_push && !req_full;

   always_comb begin
      count_in = count_ff;
      if (accept && (req_data.kind != wfp_pkg::KIND_QUERY)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Stage one holds the item and its window position; stage two the coefficient.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
         s1_idx_ff  <= count_ff;
      end
      s2_kind_ff <= s1_item_ff.kind;
      s2_x_ff    <= s1_item_ff.sample;
      s2_w_ff    <= WIN[s1_idx_ff];
      s2_addr_ff <= bit_rev(s1_idx_ff);
      s2_last_ff <= (s1_item_ff.kind != wfp_pkg::KIND_QUERY) &&
                    (s1_idx_ff == LG'(WINDOW_POINTS - 1));
      s2_qlo_ff  <= s1_item_ff.query_low_bin;
      s2_qhi_ff  <= s1_item_ff.query_high_bin;
   end

   // Windowed sample, rounded to the store format.
   assign prod    = s2_x_ff * $signed({1'b0, s2_w_ff});
   assign rounded = 34'(prod) + 34'sd8192;

   always_comb begin
      mid_item.kind  = (s2_kind_ff == wfp_pkg::KIND_QUERY) ? wfp_pkg::JOB_QUERY
                                                           : wfp_pkg::JOB_SAMPLE;
      mid_item.last  = s2_last_ff;
      mid_item.addr  = wfp_pkg::ADDR_MAX_W'(s2_addr_ff);
      mid_item.value = wfp_pkg::STORE_W'(rounded >>> 14);
      mid_item.qlo   = s2_qlo_ff;
      mid_item.qhi   = s2_qhi_ff;
   end

   assign mid_push = s2_vld_ff;

endmodule

// ===== rtl/wfp_back.sv =====
// Back end: sample store, FFT butterfly sequencer, magnitude unit and peak search.
// Depends on wfp_pkg for the job and result types and the sine used for twiddles.
module wfp_back #(
   parameter int WINDOW_POINTS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             mid_empty,
   output logic             mid_pop,
   input  wfp_pkg::job_type mid_item,
   input  logic [6:0]       auto_low,
   input  logic [7:0]       auto_high,
   input  logic             out_full,
   output logic             out_push,
   output wfp_pkg::rsp_type out_item
);

   localparam int LG     = $clog2(WINDOW_POINTS);
   localparam int HALF   = WINDOW_POINTS / 2;
   localparam int BIN_W  = LG - 1;
   localparam int STG_W  = $clog2(LG);
   localparam int SRCH_W = (LG > 8) ? LG : 8;
   localparam int SW     = wfp_pkg::STORE_W;
   localparam int WORD_W = 2 * SW;

   typedef enum logic [10:0] {
      B_IDLE   = 11'b000_0000_0001,
      B_RD     = 11'b000_0000_0010,
      B_MUL    = 11'b000_0000_0100,
      B_WA     = 11'b000_0000_1000,
      B_WB     = 11'b000_0001_0000,
      B_MG_RD  = 11'b000_0010_0000,
      B_MG_SQ  = 11'b000_0100_0000,
      B_MG_SUM = 11'b000_1000_0000,
      B_MG_RT  = 11'b001_0000_0000,
      B_PK_RUN = 11'b010_0000_0000,
      B_PK_OUT = 11'b100_0000_0000
   } back_state_type;

   // Twiddle {cos, -sin} for every index k below N/2 of a length-N transform.
   function automatic logic [HALF-1:0][31:0] build_twiddle();
      logic [HALF-1:0][31:0] tab;
      logic [31:0]           ph;
      logic signed [15:0]    c;
      logic signed [15:0]    s;
      for (int k = 0; k < HALF; k++) begin
         ph     = 32'(k) << (32 - LG);
         c      = wfp_pkg::sin_q15(ph + 32'(wfp_pkg::QUARTER_TURN));
         s      = wfp_pkg::sin_q15(ph);
         tab[k] = {c, -s};
      end
      return tab;
   endfunction

   localparam logic [HALF-1:0][31:0] TW = build_twiddle();

   function automatic logic signed [SW-1:0] sat18(input logic signed [35:0] v);
      logic signed [SW-1:0] r;
      if (v > 36'sd131071) begin
         r = 18'sd131071;
      end else if (v < -36'sd131072) begin
         r = -18'sd131072;
      end else begin
         r = SW'(v);
      end
      return r;
   endfunction

   // Storage.
   logic [WORD_W-1:0]         data_mem [WINDOW_POINTS];
   logic [wfp_pkg::MAG_W-1:0] mag_mem  [HALF];

   back_state_type            state_ff, state_in;
   logic [BIN_W-1:0]          n_ff, n_in;
   logic [STG_W-1:0]          stg_ff, stg_in;
   logic [BIN_W-1:0]          mi_ff, mi_in;
   logic [4:0]                it_ff, it_in;
   logic [SRCH_W-1:0]         pi_ff, pi_in;
   logic [SRCH_W-1:0]         end_ff, end_in;
   logic                      src_ff, src_in;
   logic [wfp_pkg::MAG_W-1:0] best_ff, best_in;
   logic [BIN_W-1:0]          bin_ff, bin_in;
   logic                      pend_ff, pend_in;
   logic                      mag_valid_ff, mag_valid_in;

   logic [WORD_W-1:0]         rd_a_ff, rd_b_ff;
   logic [31:0]               tw_ff;
   logic signed [35:0]        p0_ff, p1_ff, p2_ff, p3_ff;
   logic [WORD_W-1:0]         bval_ff, bval_in;
   logic [35:0]               e_ff, e_in;
   logic [19:0]               rem_ff, rem_in;
   logic [17:0]               root_ff, root_in;
   logic [BIN_W-1:0]          pend_bin_ff;
   logic [wfp_pkg::MAG_W-1:0] mag_rd_ff;

   logic [BIN_W-1:0]          jmask, j_idx, hi_part, tw_idx;
   logic [STG_W-1:0]          tw_shift;
   logic [LG-1:0]             bf_a, bf_b, rd_addr_a;
   logic                      mem_we;
   logic [LG-1:0]             mem_wa;
   logic [WORD_W-1:0]         mem_wd;
   logic                      mag_we;
   logic [wfp_pkg::MAG_W-1:0] mag_wd;
   logic                      mg_phase;
   logic signed [SW-1:0]      mul_a0, mul_b0, mul_a1, mul_b1, wr, wi, vr, vi;
   logic signed [35:0]        tr, ti, ur, ui;
   logic [21:0]               rem_t, trial;
   logic                      ge;
   logic [19:0]               rem_n;
   logic [17:0]               root_n;
   logic                      issue;
   logic [wfp_pkg::MAG_W-1:0] magv;
   logic [SRCH_W-1:0]         qhi_clip;
   logic [SRCH_W-1:0]         ahi;

   // Butterfly addressing: a zero is inserted at the stage bit of the counter.
   assign jmask    = ~({BIN_W{1'b1}} << stg_ff);
   assign j_idx    = n_ff & jmask;
   assign hi_part  = n_ff & ~jmask;
   assign bf_a     = {hi_part, 1'b0} | {1'b0, j_idx};
   assign bf_b     = bf_a | (LG'(1) << stg_ff);
   assign tw_shift = STG_W'(LG - 1) - stg_ff;
   assign tw_idx   = j_idx << tw_shift;

   assign mg_phase  = (state_ff == B_MG_RD) || (state_ff == B_MG_SQ);
   assign rd_addr_a = (state_ff == B_MG_RD) ? {1'b0, mi_ff} : bf_a;

   // Data store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         data_mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= data_mem[rd_addr_a];
      rd_b_ff <= data_mem[bf_b];
      tw_ff   <= TW[tw_idx];
   end

   // Shared multipliers: the complex product, or the two squares of a bin.
   assign wr = SW'($signed(tw_ff[31:16]));
   assign wi = SW'($signed(tw_ff[15:0]));
   assign vr = $signed(rd_b_ff[WORD_W-1:SW]);
   assign vi = $signed(rd_b_ff[SW-1:0]);
   assign mul_a0 = mg_phase ? $signed(rd_a_ff[WORD_W-1:SW]) : wr;
   assign mul_b0 = mg_phase ? $signed(rd_a_ff[WORD_W-1:SW]) : vr;
   assign mul_a1 = mg_phase ? $signed(rd_a_ff[SW-1:0]) : wi;
   assign mul_b1 = mg_phase ? $signed(rd_a_ff[SW-1:0]) : vi;

   always_ff @(posedge clock) begin
      p0_ff <= mul_a0 * mul_b0;
      p1_ff <= mul_a1 * mul_b1;
      p2_ff <= wr * vi;
      p3_ff <= wi * vr;
   end

   // Butterfly sums with rounding of the twiddle product.
   assign tr = (p0_ff - p1_ff + 36'sd16384) >>> 15;
   assign ti = (p2_ff + p3_ff + 36'sd16384) >>> 15;
   assign ur = 36'($signed(rd_a_ff[WORD_W-1:SW]));
   assign ui = 36'($signed(rd_a_ff[SW-1:0]));

   // One square-root digit per cycle.
   assign rem_t  = {rem_ff, e_ff[35:34]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign ge     = (rem_t >= trial);
   assign rem_n  = ge ? 20'(rem_t - trial) : 20'(rem_t);
   assign root_n = {root_ff[16:0], ge};
   assign mag_wd = (root_n > 18'd65535) ? 16'hFFFF : root_n[15:0];

   // Magnitude store with registered read; unwritten until the first window ends.
   always_ff @(posedge clock) begin
      if (mag_we) begin
         mag_mem[mi_ff] <= mag_wd;
      end
      mag_rd_ff   <= mag_mem[pi_ff[BIN_W-1:0]];
      pend_bin_ff <= pi_ff[BIN_W-1:0];
   end

   assign issue    = (pi_ff < end_ff);
   assign magv     = mag_valid_ff ? mag_rd_ff : '0;
   assign qhi_clip = (SRCH_W'(mid_item.qhi) > SRCH_W'(HALF - 1)) ? SRCH_W'(HALF - 1)
                                                                 : SRCH_W'(mid_item.qhi);
   assign ahi      = (SRCH_W'(auto_high) > SRCH_W'(HALF)) ? SRCH_W'(HALF)
                                                          : SRCH_W'(auto_high);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      stg_in       = stg_ff;
      mi_in        = mi_ff;
      it_in        = it_ff;
      pi_in        = pi_ff;
      end_in       = end_ff;
      src_in       = src_ff;
      best_in      = best_ff;
      bin_in       = bin_ff;
      pend_in      = 1'b0;
      mag_valid_in = mag_valid_ff;
      bval_in      = bval_ff;
      e_in         = e_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      mem_we       = 1'b0;
      mem_wa       = bf_a;
      mem_wd       = {sat18((ur + tr) >>> 1), sat18((ui + ti) >>> 1)};
      mag_we       = 1'b0;
      mid_pop      = 1'b0;
      out_push     = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!mid_empty) begin
               mid_pop = 1'b1;
               if (mid_item.kind == wfp_pkg::JOB_QUERY) begin
                  pi_in    = SRCH_W'(mid_item.qlo);
                  end_in   = qhi_clip + 1'b1;
                  src_in   = wfp_pkg::SRC_QUERY;
                  best_in  = '0;
                  bin_in   = '0;
                  state_in = B_PK_RUN;
               end else begin
                  mem_we = 1'b1;
                  mem_wa = mid_item.addr[LG-1:0];
                  mem_wd = {mid_item.value, {SW{1'b0}}};
                  if (mid_item.last) begin
                     n_in     = '0;
                     stg_in   = '0;
                     state_in = B_RD;
                  end
               end
            end
         end
         B_RD: begin
            state_in = B_MUL;
         end
         B_MUL: begin
            state_in = B_WA;
         end
         B_WA: begin
            mem_we   = 1'b1;
            bval_in  = {sat18((ur - tr) >>> 1), sat18((ui - ti) >>> 1)};
            state_in = B_WB;
         end
         B_WB: begin
            mem_we = 1'b1;
            mem_wa = bf_b;
            mem_wd = bval_ff;
            if (n_ff == BIN_W'(HALF - 1)) begin
               n_in = '0;
               if (stg_ff == STG_W'(LG - 1)) begin
                  mi_in    = '0;
                  state_in = B_MG_RD;
               end else begin
                  stg_in   = stg_ff + 1'b1;
                  state_in = B_RD;
               end
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = B_RD;
            end
         end
         B_MG_RD: begin
            state_in = B_MG_SQ;
         end
         B_MG_SQ: begin
            state_in = B_MG_SUM;
         end
         B_MG_SUM: begin
            e_in     = 36'(p0_ff) + 36'(p1_ff);
            rem_in   = '0;
            root_in  = '0;
            it_in    = '0;
            state_in = B_MG_RT;
         end
         B_MG_RT: begin
            rem_in  = rem_n;
            root_in = root_n;
            e_in    = e_ff << 2;
            it_in   = it_ff + 1'b1;
            if (it_ff == 5'(wfp_pkg::SQRT_STEPS - 1)) begin
               mag_we = 1'b1;
               mi_in  = mi_ff + 1'b1;
               if (mi_ff == BIN_W'(HALF - 1)) begin
                  mag_valid_in = 1'b1;
                  pi_in        = SRCH_W'(auto_low);
                  end_in       = ahi;
                  src_in       = wfp_pkg::SRC_WINDOW;
                  best_in      = '0;
                  bin_in       = '0;
                  state_in     = B_PK_RUN;
               end else begin
                  state_in = B_MG_RD;
               end
            end
         end
         B_PK_RUN: begin
            pend_in = issue;
            if (issue) begin
               pi_in = pi_ff + 1'b1;
            end
            if (pend_ff && (magv > best_ff)) begin
               best_in = magv;
               bin_in  = pend_bin_ff;
            end
            if (!issue && !pend_ff) begin
               state_in = B_PK_OUT;
            end
         end
         B_PK_OUT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         n_ff         <= '0;
         stg_ff       <= '0;
         mi_ff        <= '0;
         it_ff        <= '0;
         pi_ff        <= '0;
         end_ff       <= '0;
         src_ff       <= 1'b0;
         best_ff      <= '0;
         bin_ff       <= '0;
         pend_ff      <= 1'b0;
         mag_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         stg_ff       <= stg_in;
         mi_ff        <= mi_in;
         it_ff        <= it_in;
         pi_ff        <= pi_in;
         end_ff       <= end_in;
         src_ff       <= src_in;
         best_ff      <= best_in;
         bin_ff       <= bin_in;
         pend_ff      <= pend_in;
         mag_valid_ff <= mag_valid_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      bval_ff <= bval_in;
      e_ff    <= e_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   always_comb begin
      out_item.source         = src_ff;
      out_item.peak_bin       = wfp_pkg::BIN_OUT_W'(bin_ff);
      out_item.peak_magnitude = best_ff;
   end

endmodule

// ===== rtl/windowed_fft_peak_finder.sv =====
// Top level of the windowed FFT peak finder: configuration registers and queues.
// Depends on wfp_pkg, wfp_fifo, wfp_front and wfp_back.
//
// Usage. Items enter on the req_ channel (push while full is low). A sample item
// is windowed and stored; the sample that completes a window of WINDOW_POINTS
// starts the transform, and a query item searches the stored magnitudes.
// Results leave through the rsp_ channel, a two-beat queue: the oldest result
// shows while rsp_empty is low and leaves when rsp_pop is high.
// The csr_ channel writes the automatic search band; it is always ready and
// should only be used while the block is idle.
// A sample passes the front stages and the job queue before it is stored. A full
// window then runs through the butterfly sequencer (one shared butterfly, each pass
// through read, multiply and two write states), the magnitude unit (a digit-serial
// square root per bin) and the peak search, which reads the band one bin at a time.
// A query runs only the peak search, over its own bin range.
// Reset empties both queues, sets the band to start at bin 5 and end before
// bin 51, and marks the magnitude store as all zeros; no clearing pass is needed.
// When the receiver stalls, the result queue fills, the back end waits and the
// job queue backs up until req_full rises; nothing is dropped.
module windowed_fft_peak_finder #(
   parameter int WINDOW_POINTS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  wfp_pkg::req_type                  req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output wfp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wfp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int JOB_W = $bits(wfp_pkg::job_type);
   localparam int RSP_W = $bits(wfp_pkg::rsp_type);

   logic [6:0]                      auto_low_ff, auto_low_in;
   logic [7:0]                      auto_high_ff, auto_high_in;
   logic                            mid_push;
   logic                            mid_pop;
   logic                            mid_empty;
   logic                            mid_full;
   logic [wfp_pkg::MID_CNT_W-1:0]   mid_count;
   wfp_pkg::job_type                mid_in_item;
   logic [JOB_W-1:0]                mid_out_bits;
   logic                            out_push;
   logic                            out_full;
   wfp_pkg::rsp_type                out_item;
   logic [RSP_W-1:0]                rsp_bits;
   logic [$clog2(wfp_pkg::OUT_DEPTH+1)-1:0] out_count;

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_comb begin
      auto_low_in  = auto_low_ff;
      auto_high_in = auto_high_ff;
      if (csr_valid) begin
         priority case (csr_index)
            wfp_pkg::CSR_AUTO_LOW:  auto_low_in  = csr_wdata[6:0];
            wfp_pkg::CSR_AUTO_HIGH: auto_high_in = csr_wdata;
            default: begin
               auto_low_in  = auto_low_ff;
               auto_high_in = auto_high_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_low_ff  <= wfp_pkg::AUTO_LOW_RESET;
         auto_high_ff <= wfp_pkg::AUTO_HIGH_RESET;
      end else begin
         auto_low_ff  <= auto_low_in;
         auto_high_ff <= auto_high_in;
      end
   end

   wfp_front #(.WINDOW_POINTS(WINDOW_POINTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .mid_count (mid_count),
      .mid_push  (mid_push),
      .mid_item  (mid_in_item)
   );

   // Job queue between front and back; the front reserves room before accepting.
   wfp_fifo #(.DEPTH(wfp_pkg::MID_DEPTH), .WIDTH(JOB_W)) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_in_item),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_out_bits),
      .empty (mid_empty),
      .count (mid_count)
   );

   wfp_back #(.WINDOW_POINTS(WINDOW_POINTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_item  (wfp_pkg::job_type'(mid_out_bits)),
      .auto_low  (auto_low_ff),
      .auto_high (auto_high_ff),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   // Result queue towards the receiver.
   wfp_fifo #(.DEPTH(wfp_pkg::OUT_DEPTH), .WIDTH(RSP_W)) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_item),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty),
      .count (out_count)
   );

   assign rsp_data = wfp_pkg::rsp_type'(rsp_bits);

   // The job queue never overflows and the result count is not needed outside.
   logic unused_status;
   assign unused_status = mid_full ^ (|out_count);

endmodule

// ===== rtl/wfp_checker.sv =====
// Port-level checks for the windowed FFT peak finder, bound to the top level.
// Depends on wfp_pkg for the payload types.
module wfp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_push,
   input logic                              req_full,
   input wfp_pkg::req_type                  req_data,
   input logic                              rsp_empty,
   input logic                              rsp_pop,
   input wfp_pkg::rsp_type                  rsp_data,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [wfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input logic [wfp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // A waiting result beat stays put until it is popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");

   // Straight after reset both queues are empty and input is open.
   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // A zero peak can only be reported at bin zero.
   a_zero_peak: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.peak_magnitude == '0)) |-> (rsp_data.peak_bin == '0))
      else $error("zero magnitude reported at a non-zero bin");

   // The configuration port never stalls.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind windowed_fft_peak_finder wfp_checker u_checker (.*);

// ===== bench/windowed_fft_peak_finder_test.sv =====
// Self-checking bench for the windowed FFT peak finder: a scoreboard model of the
// windowing, radix-2 transform and peak search, fed by a queued driver. Needs wfp_pkg.
module windowed_fft_peak_finder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POINTS     = 256;
   localparam int HALF       = POINTS / 2;
   localparam int STAGES     = 8;
   localparam int HANG_LIMIT = 40000;
   localparam int SETTLE     = 300;
   localparam logic [wfp_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 4'd9;

   logic                            clock;
   logic                            reset;
   logic                            req_push;
   logic                            req_full;
   wfp_pkg::req_type                req_data;
   logic                            rsp_empty;
   logic                            rsp_pop;
   wfp_pkg::rsp_type                rsp_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [wfp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [wfp_pkg::CSR_DATA_W-1:0]  csr_wdata;

   windowed_fft_peak_finder dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Scoreboard state: working spectrum, magnitudes, sample position and band.
   longint    spec_re [POINTS];
   longint    spec_im [POINTS];
   bit [15:0] bin_mag [HALF];
   int        fill_pos;
   bit [6:0]  band_lo;
   bit [7:0]  band_hi;

   wfp_pkg::req_type pending_items[$];
   wfp_pkg::rsp_type peaks_due[$];
   int        error_count;
   int        idle_cycles;
   bit        req_taken;
   bit        calm;

   // Clock and the single reset pulse.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Q15 sine of a phase in turns scaled by 2^32, odd polynomial by Horner.
   function automatic longint sine_q15(input bit [31:0] ph);
      longint unsigned z, z2, t, s, q;
      z = ph[29:0];
      if (ph[30]) begin
         z = 64'h4000_0000 - z;
      end
      z2 = (z * z) >> 30;
      t  = 64'd5026995 - ((z2 * 64'd172272) >> 30);
      t  = 64'd85569306 - ((z2 * t) >> 30);
      t  = 64'd693598668 - ((z2 * t) >> 30);
      t  = 64'd1686629713 - ((z2 * t) >> 30);
      s  = (z * t) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return ph[31] ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp18(input longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   // Integer square root, two bits of the operand per step.
   function automatic longint unsigned root_floor(input longint unsigned e);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > e) b = b >> 2;
      while (b != 0) begin
         if (e >= r + b) begin
            e = e - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // First strictly largest stored magnitude in [lo, stop).
   function automatic wfp_pkg::rsp_type search_peak(input int lo, input int stop,
                                                    input logic src);
      wfp_pkg::rsp_type res;
      bit [15:0]        best;
      int               best_bin;
      best = 0;
      best_bin = 0;
      if (stop > HALF) stop = HALF;
      for (int i = lo; i < stop; i++) begin
         if (bin_mag[i] > best) begin
            best = bin_mag[i];
            best_bin = i;
         end
      end
      res.source = src;
      res.peak_bin = best_bin[6:0];
      res.peak_magnitude = best;
      return res;
   endfunction

   // In-place decimation-in-time transform with halving, then magnitudes.
   task automatic transform_window();
      bit [31:0] ph;
      longint    wr, wi, ur, ui, vr, vi, tr, ti;
      int        half_len, a, b;
      for (int st = 1; st <= STAGES; st++) begin
         half_len = 1 << (st - 1);
         for (int i = 0; i < POINTS; i += 2 * half_len) begin
            for (int j = 0; j < half_len; j++) begin
               ph = 32'(j) << (32 - st);
               wr = sine_q15(ph + 32'h4000_0000);
               wi = -sine_q15(ph);
               a  = i + j;
               b  = a + half_len;
               ur = spec_re[a];
               ui = spec_im[a];
               vr = spec_re[b];
               vi = spec_im[b];
               tr = (wr * vr - wi * vi + 16384) >>> 15;
               ti = (wr * vi + wi * vr + 16384) >>> 15;
               spec_re[a] = clamp18((ur + tr) >>> 1);
               spec_im[a] = clamp18((ui + ti) >>> 1);
               spec_re[b] = clamp18((ur - tr) >>> 1);
               spec_im[b] = clamp18((ui - ti) >>> 1);
            end
         end
      end
      for (int i = 0; i < HALF; i++) begin
         longint unsigned m;
         m = root_floor(longint'(spec_re[i] * spec_re[i] + spec_im[i] * spec_im[i]));
         bin_mag[i] = (m > 65535) ? 16'hFFFF : m[15:0];
      end
   endtask

   // Scoreboard step for one accepted item.
   task automatic absorb_item(input wfp_pkg::req_type it);
      bit [31:0] ph;
      bit [7:0]  rev;
      longint    x, c, w, v;
      int        top;
      if (it.kind == wfp_pkg::KIND_QUERY) begin
         top = (it.query_high_bin > HALF - 1) ? HALF - 1 : it.query_high_bin;
         peaks_due.push_back(search_peak(it.query_low_bin, top + 1, wfp_pkg::SRC_QUERY));
      end else begin
         x  = it.sample;
         ph = 32'((longint'(fill_pos) << 32) / (POINTS - 1));
         c  = sine_q15(ph + 32'h4000_0000);
         w  = (32768 - c) >>> 1;
         v  = (x * w + 8192) >>> 14;
         for (int k = 0; k < STAGES; k++) rev[k] = fill_pos[STAGES-1-k];
         spec_re[rev] = clamp18(v);
         spec_im[rev] = 0;
         fill_pos++;
         if (fill_pos == POINTS) begin
            fill_pos = 0;
            transform_window();
            peaks_due.push_back(search_peak(band_lo, band_hi, wfp_pkg::SRC_WINDOW));
         end
      end
   endtask

   function automatic int next_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   // Monitor: every handshake is sampled at the rising edge.
   always @(posedge clock) begin
      wfp_pkg::rsp_type got;
      wfp_pkg::rsp_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         fill_pos    = 0;
         band_lo     = wfp_pkg::AUTO_LOW_RESET;
         band_hi     = wfp_pkg::AUTO_HIGH_RESET;
         idle_cycles = 0;
         for (int i = 0; i < HALF; i++) bin_mag[i] = 0;
      end else begin
         req_taken <= req_push && !req_full;
         idle_cycles++;
         if (req_push && !req_full) begin
            absorb_item(req_data);
            idle_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            idle_cycles = 0;
            case (csr_index)
               wfp_pkg::CSR_AUTO_LOW:  band_lo = csr_wdata[6:0];
               wfp_pkg::CSR_AUTO_HIGH: band_hi = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            idle_cycles = 0;
            got = rsp_data;
            if (peaks_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected result bin %0d", got.peak_bin));
            end else begin
               want = peaks_due.pop_front();
               if (got.source !== want.source)
                  flag_mismatch($sformatf("source %0b, want %0b", got.source, want.source));
               if (got.peak_bin !== want.peak_bin)
                  flag_mismatch($sformatf("bin %0d, want %0d", got.peak_bin, want.peak_bin));
               if (got.peak_magnitude !== want.peak_magnitude)
                  flag_mismatch($sformatf("magnitude %0d, want %0d",
                                          got.peak_magnitude, want.peak_magnitude));
            end
         end
         if (idle_cycles >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Driver: a beat is held until taken, then the next one follows a random gap.
   int send_gap = 0;
   int pop_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         if (!(req_push && !req_taken)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               req_push <= 1'b1;
               send_gap = next_gap();
            end else begin
               req_push <= 1'b0;
            end
         end
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            pop_gap = next_gap();
         end
      end
   end

   task automatic queue_query(input int lo, input int hi);
      wfp_pkg::req_type it;
      it.kind = wfp_pkg::KIND_QUERY;
      it.sample = 16'($urandom());
      it.query_low_bin = 8'(lo);
      it.query_high_bin = 8'(hi);
      pending_items.push_back(it);
   endtask

   task automatic queue_sample(input int value);
      wfp_pkg::req_type it;
      it.kind = ~wfp_pkg::KIND_QUERY;
      it.sample = 16'(value);
      it.query_low_bin = 8'($urandom());
      it.query_high_bin = 8'($urandom());
      pending_items.push_back(it);
   endtask

   task automatic queue_random_query();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         queue_query($urandom_range(0, 127), $urandom_range(0, 127));
      end else begin
         queue_query($urandom_range(0, 255), $urandom_range(0, 255));
      end
   endtask

   // Samples of a window: a square tone with noise, full-range noise, or rail values.
   task automatic queue_window(input int style, input int queries, input int count);
      int period, amp, s;
      period = $urandom_range(2, 64);
      amp    = $urandom_range(1000, 32767);
      for (int i = 0; i < count; i++) begin
         case (style)
            0: begin
               s = ((i % period) < period / 2) ? amp : -amp;
               s = s + $signed($urandom_range(0, 4095)) - 2048;
            end
            1: s = $signed(16'($urandom()));
            default: s = ((i % 4) < 2) ? 32767 : -32768;
         endcase
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         queue_sample(s);
         if ($urandom_range(0, POINTS - 1) < queries) queue_random_query();
      end
   endtask

   task automatic csr_write(input logic [wfp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every item has gone in and every result has come out.
   task automatic drain();
      while (pending_items.size() > 0 || req_push || peaks_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Stimulus: a directed window under the reset band, then a partial window.
   initial begin
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_data  = '0;
      calm      = 1'b1;
      error_count = 0;
      @(negedge reset);

      // Queries on the cleared store, reversed and oversized ranges.
      queue_query(0, 255);
      queue_query(10, 5);
      queue_query(255, 255);
      queue_query(127, 127);
      queue_query(0, 0);
      queue_sample(32767);
      queue_sample(-32768);
      queue_sample(0);
      queue_sample(-1);
      queue_query(200, 100);
      for (int i = 4; i < POINTS; i++) queue_sample((i % 8 < 4) ? 30000 : -30000);
      queue_query(0, 127);
      queue_query(3, 200);
      drain();

      // Band writes, including a masked low bin and an unmapped index.
      calm = 1'b0;
      csr_write(wfp_pkg::CSR_AUTO_LOW, 8'hFF);
      csr_write(wfp_pkg::CSR_AUTO_HIGH, 8'd255);
      csr_write(CSR_UNMAPPED, 8'h00);

      // A window that never completes, with idling on both sides.
      queue_window(1, 20, 150);
      for (int i = 0; i < 20; i++) queue_random_query();
      drain();

      if (error_count == 0 && peaks_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
